// ===== hw/rtl/bsmm_pkg.sv =====
package bsmm_pkg;

    // Fixed geometry
    localparam int SLOTS_PER_BLOCK = 16;
    localparam int SLOT_W          = 4;
    localparam int OFFSET_W        = 12;
    localparam int SEGMENT_WORDS   = 4096;
    localparam int ENTRY_W         = 8;
    localparam int TARGET_W        = 7;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULE_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGS_PER_MOD  = 1'b1;
    localparam logic [4:0]           MODULE_COUNT_RST  = 5'd16;
    localparam logic [3:0]           SEGS_PER_MOD_RST  = 4'd8;

    localparam logic [15:0] UNMAPPED_WORD = 16'hdead;

    // Request codes
    typedef enum logic [1:0] {
        FUNC_READ      = 2'd0,
        FUNC_WRITE     = 2'd1,
        FUNC_ADD_MAP   = 2'd2,
        FUNC_CLEAR_MAP = 2'd3
    } bsmm_func_t;

    typedef struct packed {
        bsmm_func_t  func;
        logic [3:0]  block;
        logic [15:0] addr;
        logic [3:0]  map_segment_slot;
        logic [15:0] write_data;
        logic [3:0]  module_req;
        logic [2:0]  segment;
        logic        user_mode;
    } bsmm_req_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        status;
        logic        nomem_interrupt;
    } bsmm_rsp_t;

    // Map table update from the resolve stage
    typedef struct packed {
        logic                set;
        logic                clear;
        logic                clear_all;
        logic [ENTRY_W-1:0]  entry;
        logic [TARGET_W-1:0] target;
    } bsmm_map_upd_t;

    // Map table lookup result
    typedef struct packed {
        logic                valid;
        logic [TARGET_W-1:0] target;
    } bsmm_map_rd_t;

endpackage

// ===== hw/rtl/bsmm_map.sv =====
module bsmm_map
    import bsmm_pkg::*;
#(
    parameter int BLOCKS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                lookup_en,
    input  logic [ENTRY_W-1:0]  lookup_entry,
    input  bsmm_map_upd_t       upd,
    output bsmm_map_rd_t        rd
);

    localparam int BW      = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int EW      = BW + SLOT_W;
    localparam int ENTRIES = 1 << EW;

    logic [ENTRIES-1:0]  valid_reg;
    logic [TARGET_W-1:0] target_mem [ENTRIES];
    logic [EW-1:0]       rd_entry_reg;
    logic [TARGET_W-1:0] tgt_q_reg;
    logic                fwd_hit_reg;
    logic [TARGET_W-1:0] fwd_tgt_reg;
    logic [EW-1:0]       upd_entry;
    logic [EW-1:0]       lk_entry;

    assign upd_entry = upd.entry[EW-1:0];
    assign lk_entry  = lookup_entry[EW-1:0];

    // Target memory: one write, one registered read; forward a same-cycle write
    always_ff @(posedge clk)
    begin
        if (upd.set)
        begin
            target_mem[upd_entry] <= upd.target;
        end
        if (lookup_en)
        begin
            rd_entry_reg <= lk_entry;
            tgt_q_reg    <= target_mem[lk_entry];
            fwd_hit_reg  <= upd.set && (upd_entry == lk_entry);
            fwd_tgt_reg  <= upd.target;
        end
    end

    // Valid bits, one per entry; block 0 entries are never set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (upd.clear_all)
        begin
            for (int i = SLOTS_PER_BLOCK; i < ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (upd.set)
        begin
            valid_reg[upd_entry] <= 1'b1;
        end
        else if (upd.clear)
        begin
            valid_reg[upd_entry] <= 1'b0;
        end
    end

    assign rd.valid  = valid_reg[rd_entry_reg];
    assign rd.target = fwd_hit_reg ? fwd_tgt_reg : tgt_q_reg;

endmodule

// ===== hw/rtl/bsmm_phys_mem.sv =====
module bsmm_phys_mem
#(
    parameter int DEPTH = 524288,
    parameter int AW    = 19
)
(
    input  logic          clk,
    input  logic          en,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [15:0]   wdata,
    output logic [15:0]   rdata
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rdata_reg;

    // Single port, read data registered
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/block_segment_memory_mapper_top.sv =====
// A transaction accepted at a clock edge moves into stage B, then into stage C,
//   which drives rsp and done.
// Throughput: one transaction per cycle; busy stays low. Map lookup (stage A),
//   resolve and physical memory access (stage B), result (stage C).
// Reset (rst_n, async, active low) clears all user maps and sets module_count 16,
//   segments_per_module 8; physical memory and map targets are not cleared.
module block_segment_memory_mapper_top
    import bsmm_pkg::*;
#(
    parameter int BLOCKS   = 16,
    parameter int MODULES  = 16,
    parameter int SEGMENTS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  bsmm_req_t             req,
    output logic                  done,
    output bsmm_rsp_t             rsp,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SIW   = (MODULES * SEGMENTS > 1) ? $clog2(MODULES * SEGMENTS) : 1;
    localparam int AW    = SIW + OFFSET_W;
    localparam int DEPTH = MODULES * SEGMENTS * SEGMENT_WORDS;

    logic [4:0]    module_count_reg;
    logic [3:0]    segs_per_mod_reg;
    logic          valid_b_reg;
    bsmm_req_t     req_b_reg;
    logic          valid_c_reg;
    logic          from_ram_c_reg;
    bsmm_rsp_t     rsp_c_reg;

    bsmm_map_upd_t map_upd;
    bsmm_map_rd_t  map_rd;
    logic          accept;

    logic [3:0]    slot_b;
    logic          blk_ok;
    logic [3:0]    acc_mod;
    logic [3:0]    acc_seg;
    logic          mapped;
    logic [8:0]    lin_seg;
    logic [AW-1:0] ram_addr;
    logic          ram_en;
    logic          ram_we;
    logic [15:0]   ram_q;
    logic          from_ram_next;
    bsmm_rsp_t     rsp_next;

    function automatic logic installed(input logic [3:0] m, input logic [3:0] s,
                                       input logic [4:0] mc, input logic [3:0] sc);
        logic m_ok;
        logic s_ok;
        m_ok = ({1'b0, m} < mc) && ({1'b0, m} < 5'(MODULES));
        s_ok = ({1'b0, s} < {1'b0, sc}) && ({1'b0, s} < 5'(SEGMENTS));
        return m_ok && s_ok;
    endfunction

    assign busy   = 1'b0;
    assign accept = start;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            module_count_reg <= MODULE_COUNT_RST;
            segs_per_mod_reg <= SEGS_PER_MOD_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_MODULE_COUNT: module_count_reg <= cfg_data;
                CFG_SEGS_PER_MOD: segs_per_mod_reg <= cfg_data[3:0];
                default:          module_count_reg <= module_count_reg;
            endcase
        end
    end

    // Stage A: map table lookup
    bsmm_map #(
        .BLOCKS (BLOCKS)
    ) u_map (
        .clk          (clk),
        .rst_n        (rst_n),
        .lookup_en    (accept),
        .lookup_entry ({req.block, req.addr[15:12]}),
        .upd          (map_upd),
        .rd           (map_rd)
    );

    // Stage B: resolve, map update, memory access
    always_comb
    begin
        slot_b        = req_b_reg.addr[15:12];
        blk_ok        = {1'b0, req_b_reg.block} < 5'(BLOCKS);
        map_upd       = '0;
        rsp_next      = '0;
        from_ram_next = 1'b0;
        ram_en        = 1'b0;
        ram_we        = 1'b0;

        if (req_b_reg.block == 4'd0)
        begin
            acc_mod = 4'd0;
            acc_seg = slot_b;
            mapped  = installed(acc_mod, acc_seg, module_count_reg, segs_per_mod_reg);
        end
        else
        begin
            acc_mod = map_rd.target[6:3];
            acc_seg = {1'b0, map_rd.target[2:0]};
            mapped  = blk_ok && map_rd.valid &&
                      installed(acc_mod, acc_seg, module_count_reg, segs_per_mod_reg);
        end

        lin_seg  = 9'(acc_mod) * 9'(SEGMENTS) + 9'(acc_seg);
        ram_addr = {lin_seg[SIW-1:0], req_b_reg.addr[OFFSET_W-1:0]};

        case (req_b_reg.func)
            FUNC_READ,
            FUNC_WRITE:
            begin
                if (mapped)
                begin
                    ram_en        = valid_b_reg;
                    ram_we        = (req_b_reg.func == FUNC_WRITE);
                    from_ram_next = (req_b_reg.func == FUNC_READ);
                end
                else
                begin
                    rsp_next.read_data       = (req_b_reg.func == FUNC_READ) ?
                                               UNMAPPED_WORD : 16'h0000;
                    rsp_next.status          = 1'b1;
                    rsp_next.nomem_interrupt = req_b_reg.user_mode;
                end
            end
            FUNC_ADD_MAP:
            begin
                map_upd.entry  = {req_b_reg.block, req_b_reg.map_segment_slot};
                map_upd.target = {req_b_reg.module_req, req_b_reg.segment};
                if ((req_b_reg.block == 4'd0) || !blk_ok)
                begin
                    rsp_next.status = 1'b1;
                end
                else if (installed(req_b_reg.module_req, {1'b0, req_b_reg.segment},
                                   module_count_reg, segs_per_mod_reg))
                begin
                    map_upd.set = valid_b_reg;
                end
                else
                begin
                    map_upd.clear   = valid_b_reg;
                    rsp_next.status = 1'b1;
                end
            end
            FUNC_CLEAR_MAP:
            begin
                map_upd.clear_all = valid_b_reg;
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    bsmm_phys_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_phys_mem (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (req_b_reg.write_data),
        .rdata (ram_q)
    );

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else
        begin
            valid_b_reg <= accept;
            valid_c_reg <= valid_b_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_b_reg <= req;
        end
        if (valid_b_reg)
        begin
            rsp_c_reg      <= rsp_next;
            from_ram_c_reg <= from_ram_next;
        end
    end

    // Stage C: result transaction
    assign done                = valid_c_reg;
    assign rsp.read_data       = from_ram_c_reg ? ram_q : rsp_c_reg.read_data;
    assign rsp.status          = rsp_c_reg.status;
    assign rsp.nomem_interrupt = rsp_c_reg.nomem_interrupt;

endmodule

// ===== verif/mapper_checker.sv =====
`timescale 1ns / 100ps

// Watches the request, response and register channels of the mapper, keeps its
// own copy of the map table, the physical memory and the two size registers, and
// compares every response with the oldest predicted one.
module mapper_checker
    import bsmm_pkg::*;
#(
    parameter int BLOCKS   = 16,
    parameter int MODULES  = 16,
    parameter int SEGMENTS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  bsmm_req_t             req,
    input  logic                  done,
    input  bsmm_rsp_t             rsp,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatch_count,
    output int                    awaited_count
);

    localparam int ENTRIES = BLOCKS * SLOTS_PER_BLOCK;

    // Mirror of the mapper state
    bit                  entry_valid [ENTRIES];
    logic [TARGET_W-1:0] entry_target [ENTRIES];
    logic [15:0]         phys_word [int];
    logic [4:0]          module_count;
    logic [3:0]          segs_per_module;

    // Responses predicted but not yet seen
    bsmm_rsp_t awaited_rsp [$];

    // Installed check uses the current registers, saturated at the build sizes
    function automatic bit segment_installed(int unsigned mod, int unsigned seg);
        int unsigned mods;
        int unsigned segs;
        mods = (module_count < MODULES) ? module_count : MODULES;
        segs = (segs_per_module < SEGMENTS) ? segs_per_module : SEGMENTS;
        return (mod < mods) && (seg < segs);
    endfunction

    // Logical block/address to physical word index
    function automatic bit locate_word(logic [3:0] blk, logic [15:0] addr, output int idx);
        int unsigned slot;
        int unsigned e;
        int unsigned mod;
        int unsigned seg;
        slot = addr[15:12];
        idx  = 0;
        if (blk >= BLOCKS)
            return 1'b0;
        if (blk == 0)
        begin
            mod = 0;
            seg = slot;
        end
        else
        begin
            e = blk * SLOTS_PER_BLOCK + slot;
            if (!entry_valid[e])
                return 1'b0;
            mod = entry_target[e][6:3];
            seg = entry_target[e][2:0];
        end
        if (!segment_installed(mod, seg))
            return 1'b0;
        idx = (mod * SEGMENTS + seg) * SEGMENT_WORDS + addr[11:0];
        return 1'b1;
    endfunction

    // Expected response of one request; updates the mirrored state
    function automatic bsmm_rsp_t predict_response(bsmm_req_t r);
        bsmm_rsp_t p;
        int        idx;
        int        e;
        p = '0;
        case (r.func)
            FUNC_READ, FUNC_WRITE:
            begin
                if (locate_word(r.block, r.addr, idx))
                begin
                    if (r.func == FUNC_READ)
                        p.read_data = phys_word.exists(idx) ? phys_word[idx] : 16'h0000;
                    else
                        phys_word[idx] = r.write_data;
                end
                else
                begin
                    if (r.func == FUNC_READ)
                        p.read_data = UNMAPPED_WORD;
                    p.status          = 1'b1;
                    p.nomem_interrupt = r.user_mode;
                end
            end
            FUNC_ADD_MAP:
            begin
                if (r.block == 0 || r.block >= BLOCKS)
                    p.status = 1'b1;
                else
                begin
                    e = r.block * SLOTS_PER_BLOCK + r.map_segment_slot;
                    if (segment_installed(r.module_req, r.segment))
                    begin
                        entry_valid[e]  = 1'b1;
                        entry_target[e] = {r.module_req, r.segment};
                    end
                    else
                    begin
                        // refused target also wipes the entry
                        entry_valid[e]  = 1'b0;
                        entry_target[e] = '0;
                        p.status        = 1'b1;
                    end
                end
            end
            default:
            begin
                for (e = SLOTS_PER_BLOCK; e < ENTRIES; e++)
                    entry_valid[e] = 1'b0;
            end
        endcase
        return p;
    endfunction

    // Compare, predict, and track register writes at each edge
    always @(posedge clk or negedge rst_n)
    begin : monitor
        bsmm_rsp_t want;
        if (!rst_n)
        begin
            for (int e = 0; e < ENTRIES; e++)
                entry_valid[e] = 1'b0;
            module_count    = MODULE_COUNT_RST;
            segs_per_module = SEGS_PER_MOD_RST;
            awaited_rsp.delete();
            mismatch_count  = 0;
            awaited_count   = 0;
        end
        else
        begin
            if (done)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    $error("response with no transaction pending: %p", rsp);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (rsp.read_data !== want.read_data)
                    begin
                        $error("read_data: expected %h, got %h", want.read_data,
                               rsp.read_data);
                        mismatch_count++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %b, got %b", want.status, rsp.status);
                        mismatch_count++;
                    end
                    if (rsp.nomem_interrupt !== want.nomem_interrupt)
                    begin
                        $error("nomem_interrupt: expected %b, got %b",
                               want.nomem_interrupt, rsp.nomem_interrupt);
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy)
                awaited_rsp.push_back(predict_response(req));
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_MODULE_COUNT: module_count    = cfg_data;
                    CFG_SEGS_PER_MOD: segs_per_module = cfg_data[3:0];
                    default: ;
                endcase
            end
            awaited_count = awaited_rsp.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

// Drives requests and register writes into the mapper; the checker beside the
// block predicts and compares, this module gives the verdict.
module testbench;
    import bsmm_pkg::*;

    localparam int BLOCKS       = 16;
    localparam int MODULES      = 16;
    localparam int SEGMENTS     = 8;
    localparam int ENTRIES      = BLOCKS * SLOTS_PER_BLOCK;
    localparam int RANDOM_ITEMS = 1200;
    localparam int PHASES       = 8;
    localparam int CYCLE_LIMIT  = 200000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    bsmm_req_t             req = '0;
    logic                  done;
    bsmm_rsp_t             rsp;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_MODULE_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    mismatch_count;
    int                    awaited_count;
    int                    cycle_count = 0;

    // Stimulus-side view of the maps, sizes and written words; keeps reads of
    // physical words that were never written out of the stream
    bit          map_on [ENTRIES];
    logic [6:0]  map_to [ENTRIES];
    bit          written [int];
    int unsigned mods_now = MODULES;
    int unsigned segs_now = SEGMENTS;

    // Register settings for the random phases, extremes included
    int phase_mods [PHASES] = '{16, 5, 1, 31, 2, 16, 0, 16};
    int phase_segs [PHASES] = '{8, 3, 1, 15, 8, 1, 4, 8};

    logic [11:0] offset_pool [8] = '{12'h000, 12'h001, 12'h7ff, 12'h800,
                                     12'hffe, 12'hfff, 12'h555, 12'haaa};

    block_segment_memory_mapper_top #(
        .BLOCKS   (BLOCKS),
        .MODULES  (MODULES),
        .SEGMENTS (SEGMENTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mapper_checker #(
        .BLOCKS   (BLOCKS),
        .MODULES  (MODULES),
        .SEGMENTS (SEGMENTS)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req            (req),
        .done           (done),
        .rsp            (rsp),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Watchdog
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("block_segment_memory_mapper_top verification failed");
        $finish;
    end

    function automatic bit find_word(bsmm_req_t r, output int idx);
        int unsigned slot;
        int unsigned mod;
        int unsigned seg;
        int unsigned e;
        slot = r.addr[15:12];
        idx  = 0;
        if (r.block == 0)
        begin
            mod = 0;
            seg = slot;
        end
        else
        begin
            e = r.block * SLOTS_PER_BLOCK + slot;
            if (!map_on[e])
                return 1'b0;
            mod = map_to[e][6:3];
            seg = map_to[e][2:0];
        end
        if (mod >= mods_now || seg >= segs_now)
            return 1'b0;
        idx = (mod * SEGMENTS + seg) * SEGMENT_WORDS + r.addr[11:0];
        return 1'b1;
    endfunction

    function automatic void track(bsmm_req_t r);
        int idx;
        int e;
        case (r.func)
            FUNC_WRITE:
                if (find_word(r, idx))
                    written[idx] = 1'b1;
            FUNC_ADD_MAP:
                if (r.block != 0)
                begin
                    e = r.block * SLOTS_PER_BLOCK + r.map_segment_slot;
                    map_on[e] = (r.module_req < mods_now) && (r.segment < segs_now);
                    map_to[e] = {r.module_req, r.segment};
                end
            FUNC_CLEAR_MAP:
                for (e = SLOTS_PER_BLOCK; e < ENTRIES; e++)
                    map_on[e] = 1'b0;
            default: ;
        endcase
    endfunction

    function automatic bsmm_req_t item(bsmm_func_t f, logic [3:0] blk, logic [15:0] addr,
                                       logic [3:0] slot, logic [15:0] data,
                                       logic [3:0] mod, logic [2:0] seg, logic user);
        bsmm_req_t r;
        r.func             = f;
        r.block            = blk;
        r.addr             = addr;
        r.map_segment_slot = slot;
        r.write_data       = data;
        r.module_req       = mod;
        r.segment          = seg;
        r.user_mode        = user;
        return r;
    endfunction

    // Mostly well-formed traffic on a few blocks and slots so maps get hit
    function automatic bsmm_req_t random_item();
        bsmm_req_t   r;
        int unsigned pick;
        logic [3:0]  slot;
        logic [11:0] offset;
        r = item(FUNC_READ, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)),
                 4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)),
                 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                 1'($urandom_range(0, 1)));
        pick = $urandom_range(0, 99);
        if (pick < 40)
            r.func = FUNC_READ;
        else if (pick < 75)
            r.func = FUNC_WRITE;
        else if (pick < 97)
            r.func = FUNC_ADD_MAP;
        else
            r.func = FUNC_CLEAR_MAP;

        if (r.func == FUNC_READ || r.func == FUNC_WRITE)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                r.block = 0;
            else if (pick < 85)
                r.block = 4'($urandom_range(1, 3));
            if (r.block == 0 && $urandom_range(0, 4) < 3)
                slot = 4'($urandom_range(0, segs_now > 0 ? segs_now - 1 : 0));
            else if (r.block != 0 && $urandom_range(0, 9) < 7)
                slot = 4'($urandom_range(0, 3));
            else
                slot = 4'($urandom_range(0, 15));
            offset = ($urandom_range(0, 4) < 4) ? offset_pool[$urandom_range(0, 7)]
                                                : 12'($urandom_range(0, 4095));
            if ($urandom_range(0, 6) != 0)
                r.addr = {slot, offset};
        end
        else if (r.func == FUNC_ADD_MAP)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                r.block = 0;
            else if (pick < 85)
                r.block = 4'($urandom_range(1, 3));
            else
                r.block = 4'($urandom_range(1, 15));
            if ($urandom_range(0, 4) != 0)
                r.map_segment_slot = 4'($urandom_range(0, 3));
            if ($urandom_range(0, 4) != 0)
                r.module_req = 4'($urandom_range(0, mods_now > 0 ? mods_now - 1 : 0));
            if ($urandom_range(0, 4) != 0)
                r.segment = 3'($urandom_range(0, segs_now > 0 ? segs_now - 1 : 0));
        end
        return r;
    endfunction

    // One transaction after a gap of idle cycles; start stays high across gap 0
    task automatic send(bsmm_req_t r, int gap);
        int idx;
        // a read of a never-written word becomes a write to it
        if (r.func == FUNC_READ && find_word(r, idx) && !written.exists(idx))
            r.func = FUNC_WRITE;
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        track(r);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (awaited_count != 0)
            @(negedge clk);
    endtask

    // Register writes only once the pipeline is empty
    task automatic set_config(int mods, int segs);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_MODULE_COUNT;
        cfg_data  <= CFG_DATA_W'(mods);
        @(negedge clk);
        cfg_index <= CFG_SEGS_PER_MOD;
        cfg_data  <= CFG_DATA_W'(segs);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        mods_now = (mods < MODULES) ? mods : MODULES;
        segs_now = ((segs & 15) < SEGMENTS) ? (segs & 15) : SEGMENTS;
    endtask

    initial
    begin
        bit burst;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: full geometry after reset
        send(item(FUNC_WRITE, 0, 16'h0000, 0, 16'hffff, 0, 0, 0), 0);
        send(item(FUNC_READ, 0, 16'h0000, 0, 0, 0, 0, 0), 0);
        send(item(FUNC_WRITE, 0, 16'h7fff, 15, 16'h0000, 15, 7, 1), 1);
        send(item(FUNC_READ, 0, 16'h7fff, 0, 0, 0, 0, 1), 0);
        // block 0 slot beyond installed segments, user mode
        send(item(FUNC_READ, 0, 16'h8000, 0, 0, 0, 0, 1), 2);
        send(item(FUNC_WRITE, 0, 16'hffff, 0, 16'h1234, 0, 0, 1), 0);
        // block with no map, with and without user mode
        send(item(FUNC_READ, 5, 16'h1234, 0, 0, 0, 0, 1), 0);
        send(item(FUNC_WRITE, 5, 16'h1234, 0, 16'h4321, 0, 0, 0), 3);
        // map into block 0 is refused
        send(item(FUNC_ADD_MAP, 0, 0, 3, 0, 1, 1, 0), 0);
        send(item(FUNC_ADD_MAP, 15, 0, 15, 0, 15, 7, 0), 0);
        send(item(FUNC_WRITE, 15, 16'hf000, 0, 16'ha5a5, 0, 0, 0), 0);
        send(item(FUNC_READ, 15, 16'hf000, 0, 0, 0, 0, 0), 0);
        // remap onto the segment block 0 uses: aliased word
        send(item(FUNC_ADD_MAP, 15, 0, 15, 0, 0, 0, 0), 4);
        send(item(FUNC_READ, 15, 16'hf000, 0, 0, 0, 0, 0), 0);
        send(item(FUNC_ADD_MAP, 4, 0, 1, 0, 3, 2, 0), 0);
        send(item(FUNC_WRITE, 4, 16'h1abc, 0, 16'h5a5a, 0, 0, 0), 0);
        send(item(FUNC_READ, 4, 16'h1abc, 0, 0, 0, 0, 0), 0);

        // Directed: minimum geometry, stale maps and refused targets
        set_config(1, 1);
        send(item(FUNC_READ, 15, 16'hf000, 0, 0, 0, 0, 1), 0);
        send(item(FUNC_READ, 4, 16'h1abc, 0, 0, 0, 0, 1), 0);
        send(item(FUNC_ADD_MAP, 4, 0, 1, 0, 1, 0, 0), 0);
        send(item(FUNC_ADD_MAP, 4, 0, 2, 0, 0, 1, 0), 1);
        send(item(FUNC_READ, 0, 16'h7fff, 0, 0, 0, 0, 0), 0);
        send(item(FUNC_CLEAR_MAP, 0, 0, 0, 0, 0, 0, 0), 0);
        send(item(FUNC_READ, 15, 16'hf000, 0, 0, 0, 0, 1), 0);

        // Random phases, each at its own register setting
        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_config(phase_mods[ph], phase_segs[ph]);
            burst = 1'b0;
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
            begin
                if (n % 30 == 0)
                    burst = ($urandom_range(0, 3) == 0);
                send(random_item(), burst ? 0 : $urandom_range(0, 14));
            end
        end

        // Drain, then give the pipeline time to show any stray response
        wait_drained();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && awaited_count == 0)
            $display("block_segment_memory_mapper_top verification clean");
        else
            $display("block_segment_memory_mapper_top verification failed");
        $finish;
    end

endmodule
